[sv/assert_macros.svh]
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/gbf_pkg.sv]
package gbf_pkg;

	typedef enum logic [9:0] {
		ST_LOAD   = 10'b0000000001,
		ST_ROOT   = 10'b0000000010,
		ST_FETCH  = 10'b0000000100,
		ST_EDGE   = 10'b0000001000,
		ST_VISIT  = 10'b0000010000,
		ST_POP    = 10'b0000100000,
		ST_POP2   = 10'b0001000000,
		ST_COUNT  = 10'b0010000000,
		ST_EMIT   = 10'b0100000000,
		ST_CLEAR  = 10'b1000000000
	} state_t;

	localparam int unsigned MAX_VERTICES = 32;
	localparam int unsigned MAX_EDGES = 64;
	localparam int unsigned REPORT_LIMIT = 31;

endpackage

[sv/graph_bridge_finder_top.sv]
// Bridge finder for an undirected graph held in an on-chip edge memory.
// Channels: edge input (end_a, end_b, last_edge) with in_valid / in_stall,
// result output (bridge_edge, bridge_total, none_found, last) with
// out_valid / out_stall, and a config write channel (cfg_valid, cfg_ready,
// cfg_data) carrying vertex_count.
// Each edge is accepted without a stall while loading. The edge marked last
// starts the depth-first search; input stalls until all results of that graph
// are transferred and the marks are cleared. One fetch of the edge memory per
// cycle drives the search, each scanned edge of a visited vertex taking a
// fetch step and an edge step; then all mark positions are counted, then the
// marks are walked up to the highest reported bridge id, each result loaded
// into the output register when its mark is reached and the register is
// free, then all mark positions are cleared.
// A stalled result holds in the output register until transferred.
// Reset: vertex_count returns to 32, the edge store empties, marks clear.
module graph_bridge_finder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [4:0] end_a,
	input  logic [4:0] end_b,
	input  logic       last_edge,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] bridge_edge,
	output logic [4:0] bridge_total,
	output logic       none_found,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data
);
	import gbf_pkg::*;
	`include "assert_macros.svh"

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int TW = $clog2(MAX_VERTICES + 1);

	state_t state_q;
	logic [5:0] vcount_q;
	logic [CW-1:0] loaded_q;
	logic [4:0] mem_a [MAX_EDGES];
	logic [4:0] mem_b [MAX_EDGES];
	logic [4:0] rd_a_q, rd_b_q;
	logic [TW-1:0] etime [MAX_VERTICES];
	logic [TW-1:0] llink [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_EDGES:0] marks_q;
	logic [VW-1:0] stk_v [MAX_VERTICES];
	logic [CW-1:0] stk_via [MAX_VERTICES];
	logic [CW-1:0] stk_scan [MAX_VERTICES];
	logic [TW-1:0] sp_q;
	logic [TW-1:0] clock_q;
	logic [VW:0] root_q;
	logic [VW-1:0] v_q, child_q;
	logic [CW-1:0] via_q, scan_q, child_via_q, idx_q;
	logic [TW:0] n_q;
	logic [4:0] total_q, rep_q;

	// effective vertex count, clipped to the array size
	logic [TW:0] n_eff;
	always_comb begin
		if ({1'b0, vcount_q} > 7'(MAX_VERTICES)) n_eff = (TW+1)'(MAX_VERTICES);
		else n_eff = (TW+1)'(vcount_q);
	end

	assign cfg_ready = state_q == ST_LOAD;
	assign in_stall = state_q != ST_LOAD;
	logic in_xfer, out_xfer;
	assign in_xfer = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// edge decode against the current vertex
	logic a_ok, b_ok, hit;
	logic [4:0] to_v;
	logic [CW-1:0] cur_id;
	assign a_ok = (TW+1)'(rd_a_q) < n_q;
	assign b_ok = (TW+1)'(rd_b_q) < n_q;
	always_comb begin
		hit = 1'b0;
		to_v = rd_a_q;
		if (a_ok && b_ok) begin
			if (rd_a_q == 5'(v_q)) begin
				hit = 1'b1;
				to_v = rd_b_q;
			end else if (rd_b_q == 5'(v_q)) begin
				hit = 1'b1;
				to_v = rd_a_q;
			end
		end
	end
	assign cur_id = scan_q;

	// edge memory: write on load, read for scan
	always_ff @(posedge clk) begin
		if (in_xfer && loaded_q < CW'(MAX_EDGES)) begin
			mem_a[loaded_q[EW-1:0]] <= end_a;
			mem_b[loaded_q[EW-1:0]] <= end_b;
		end
		rd_a_q <= mem_a[scan_q[EW-1:0]];
		rd_b_q <= mem_b[scan_q[EW-1:0]];
	end

	logic [VW-1:0] to_idx;
	assign to_idx = VW'(to_v);

	// follow the edge unless it is the one we arrived by; descend if unvisited and the stack has room
	logic take_edge, descend;
	assign take_edge = hit && (cur_id + 1'b1) != via_q;
	assign descend = take_edge && !visited_q[to_idx] && sp_q < TW'(MAX_VERTICES);

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			vcount_q <= 6'd32;
			loaded_q <= '0;
			visited_q <= '0;
			marks_q <= '0;
			sp_q <= '0;
			clock_q <= '0;
			root_q <= '0;
			out_valid <= 1'b0;
			total_q <= '0;
			rep_q <= '0;
			idx_q <= '0;
			scan_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_valid) vcount_q <= cfg_data;
					if (in_xfer) begin
						if (loaded_q < CW'(MAX_EDGES)) loaded_q <= loaded_q + 1'b1;
						if (last_edge) begin
							n_q <= n_eff;
							visited_q <= '0;
							clock_q <= '0;
							root_q <= '0;
							state_q <= ST_ROOT;
						end
					end
				end
				ST_ROOT: begin
					if ({1'b0, root_q} >= n_q) begin
						idx_q <= CW'(1);
						total_q <= '0;
						state_q <= ST_COUNT;
					end else if (visited_q[root_q[VW-1:0]]) begin
						root_q <= root_q + 1'b1;
					end else begin
						v_q <= root_q[VW-1:0];
						via_q <= '0;
						scan_q <= '0;
						sp_q <= '0;
						visited_q[root_q[VW-1:0]] <= 1'b1;
						etime[root_q[VW-1:0]] <= clock_q;
						llink[root_q[VW-1:0]] <= clock_q;
						clock_q <= clock_q + 1'b1;
						root_q <= root_q + 1'b1;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (scan_q < loaded_q) state_q <= ST_EDGE;
					else if (sp_q == '0) state_q <= ST_ROOT;
					else state_q <= ST_POP;
				end
				ST_EDGE: begin
					state_q <= ST_FETCH;
					if (descend) begin
						stk_v[sp_q[VW-1:0]] <= v_q;
						stk_via[sp_q[VW-1:0]] <= via_q;
						stk_scan[sp_q[VW-1:0]] <= scan_q + 1'b1;
						sp_q <= sp_q + 1'b1;
						via_q <= cur_id + 1'b1;
						v_q <= to_idx;
						scan_q <= '0;
						visited_q[to_idx] <= 1'b1;
						etime[to_idx] <= clock_q;
						llink[to_idx] <= clock_q;
						clock_q <= clock_q + 1'b1;
					end else begin
						scan_q <= scan_q + 1'b1;
						if (take_edge && visited_q[to_idx] && etime[to_idx] < llink[v_q])
							llink[v_q] <= etime[to_idx];
					end
				end
				ST_POP: begin
					child_q <= v_q;
					child_via_q <= via_q;
					v_q <= stk_v[sp_q[VW-1:0] - 1'b1];
					via_q <= stk_via[sp_q[VW-1:0] - 1'b1];
					scan_q <= stk_scan[sp_q[VW-1:0] - 1'b1];
					sp_q <= sp_q - 1'b1;
					state_q <= ST_POP2;
				end
				ST_POP2: begin
					if (llink[child_q] < llink[v_q]) llink[v_q] <= llink[child_q];
					if (llink[child_q] > etime[v_q]) marks_q[child_via_q] <= 1'b1;
					state_q <= ST_FETCH;
				end
				ST_COUNT: begin
					if (marks_q[idx_q] && total_q != 5'(REPORT_LIMIT))
						total_q <= total_q + 1'b1;
					if (idx_q == CW'(MAX_EDGES)) begin
						idx_q <= CW'(1);
						rep_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					// load a new result once the output register is free
					if (!out_valid || out_xfer) begin
						if (total_q == '0 && rep_q == '0) begin
							bridge_edge <= '0;
							bridge_total <= '0;
							none_found <= 1'b1;
							last <= 1'b1;
							out_valid <= 1'b1;
							rep_q <= 5'd1;
						end else if (total_q == '0 || rep_q == total_q) begin
							out_valid <= 1'b0;
							idx_q <= '0;
							state_q <= ST_CLEAR;
						end else if (marks_q[idx_q]) begin
							bridge_edge <= 7'(idx_q);
							bridge_total <= total_q;
							none_found <= 1'b0;
							last <= (rep_q + 1'b1) == total_q;
							out_valid <= 1'b1;
							rep_q <= rep_q + 1'b1;
							idx_q <= idx_q + 1'b1;
						end else begin
							out_valid <= 1'b0;
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					marks_q[idx_q] <= 1'b0;
					if (idx_q == CW'(MAX_EDGES)) begin
						loaded_q <= '0;
						scan_q <= '0;
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`ASSERT_IMP(a_out_only_emit, clk, arst_n, out_valid, (state_q == ST_EMIT || state_q == ST_CLEAR))
	`ASSERT_IMP(a_stack_bound, clk, arst_n, 1'b1, sp_q <= TW'(MAX_VERTICES))
	`ASSERT_NXT(a_none_last, clk, arst_n, out_valid && none_found, last)
	`ASSERT_IMP(a_load_bound, clk, arst_n, 1'b1, loaded_q <= CW'(MAX_EDGES))

endmodule

[tb/tb_graph_bridge_finder_top.sv]
`timescale 1ns / 1ps
module tb_graph_bridge_finder_top;
	import gbf_pkg::*;

	typedef struct packed {
		logic [6:0] id;
		logic [4:0] total;
		logic       none;
		logic       fin;
	} bridge_rec_t;

	// Tracks the graph being loaded and the bridge results still owed
	class bridge_board;
		int          vcount;
		logic [4:0]  ea[64];
		logic [4:0]  eb[64];
		int          loaded;
		bridge_rec_t pending[$];
		int          errors;

		function new();
			vcount = 32;
			loaded = 0;
			errors = 0;
		endfunction

		function void report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endfunction

		// Append a result to the owed list
		function void owe(bridge_rec_t r);
			pending = {pending, r};
		endfunction

		// Store an accepted edge; on the final edge search and queue the bridges
		function void note_edge(logic [4:0] a, logic [4:0] b, logic fin);
			int n, root, v, via, scan, sp, id, to, total, rep, child, cvia;
			bit vis[32];
			bit mk[65];
			int tin[32], low[32], fv[32], fvia[32], fscan[32];
			int vclk;
			bridge_rec_t r;
			if (loaded < 64) begin
				ea[loaded] = a;
				eb[loaded] = b;
				loaded++;
			end
			if (!fin)
				return;
			n = (vcount > 32) ? 32 : vcount;
			vclk = 0;
			foreach (vis[i]) vis[i] = 0;
			foreach (mk[i]) mk[i] = 0;
			for (root = 0; root < n; root++) begin
				if (vis[root])
					continue;
				v = root; via = 0; scan = 0; sp = 0;
				vis[v] = 1; tin[v] = vclk; low[v] = vclk; vclk++;
				forever begin
					while (scan < loaded) begin
						id = scan + 1;
						scan++;
						if (ea[id-1] >= n || eb[id-1] >= n)
							continue;
						if (ea[id-1] == v)
							to = eb[id-1];
						else if (eb[id-1] == v)
							to = ea[id-1];
						else
							continue;
						if (id == via)
							continue;
						if (vis[to]) begin
							if (tin[to] < low[v])
								low[v] = tin[to];
						end else if (sp < 32) begin
							fv[sp] = v; fvia[sp] = via; fscan[sp] = scan;
							sp++;
							via = id; v = to; scan = 0;
							vis[v] = 1; tin[v] = vclk; low[v] = vclk; vclk++;
						end
					end
					if (sp == 0)
						break;
					child = v; cvia = via;
					sp--;
					v = fv[sp]; via = fvia[sp]; scan = fscan[sp];
					if (low[child] < low[v])
						low[v] = low[child];
					if (low[child] > tin[v])
						mk[cvia] = 1;
				end
			end
			total = 0;
			for (id = 1; id <= 64; id++)
				if (mk[id])
					total++;
			if (total > REPORT_LIMIT)
				total = REPORT_LIMIT;
			if (total == 0) begin
				r = '{id: 7'd0, total: 5'd0, none: 1'b1, fin: 1'b1};
				owe(r);
			end else begin
				rep = 0;
				for (id = 1; id <= 64 && rep < total; id++) begin
					if (!mk[id])
						continue;
					r = '{id: 7'(id), total: 5'(total), none: 1'b0, fin: (rep + 1 == total)};
					owe(r);
					rep++;
				end
			end
			loaded = 0;
		endfunction

		function void check_result(bridge_rec_t got);
			bridge_rec_t exp_r;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result id=%0d", got.id));
				return;
			end
			exp_r = pending.pop_front();
			if (got.id !== exp_r.id)
				report($sformatf("bridge_edge %0d, want %0d", got.id, exp_r.id));
			if (got.total !== exp_r.total)
				report($sformatf("bridge_total %0d, want %0d", got.total, exp_r.total));
			if (got.none !== exp_r.none)
				report($sformatf("none_found %0b, want %0b", got.none, exp_r.none));
			if (got.fin !== exp_r.fin)
				report($sformatf("last %0b, want %0b", got.fin, exp_r.fin));
		endfunction
	endclass

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	logic [4:0] end_a = 0;
	logic [4:0] end_b = 0;
	logic       last_edge = 0;
	logic       out_valid;
	logic       out_stall = 0;
	logic [6:0] bridge_edge;
	logic [4:0] bridge_total;
	logic       none_found;
	logic       last;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [5:0] cfg_data = 0;

	bridge_board board = new();
	int  items_sent = 0;
	bit  hold_req = 0;
	int  idle_cycles = 0;

	graph_bridge_finder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.end_a(end_a), .end_b(end_b), .last_edge(last_edge),
		.out_valid(out_valid), .out_stall(out_stall),
		.bridge_edge(bridge_edge), .bridge_total(bridge_total),
		.none_found(none_found), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result('{id: bridge_edge, total: bridge_total,
				none: none_found, fin: last});
	end

	// Drive receiver stalls: random, a calm stretch, and a long hold-off on request
	initial begin : receiver
		int hold, cyc;
		hold = 0;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 0;
				hold = 400;
			end
			if (hold > 0) begin
				out_stall = 1;
				hold--;
			end else if (cyc >= 3000 && cyc < 6000)
				out_stall = 0;
			else
				out_stall = ($urandom_range(0, 99) < 28);
		end
	end

	// Abort when nothing transfers for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= 30000) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_edge(int a, int b, bit fin);
		if (!(items_sent >= 60 && items_sent < 100) && $urandom_range(0, 99) < 28) begin
			in_valid = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1;
		end_a = 5'(a);
		end_b = 5'(b);
		last_edge = fin;
		do @(posedge clk); while (in_stall);
		board.note_edge(end_a, end_b, last_edge);
		items_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	// Wait for all owed results, then for the mark clear to finish
	task automatic settle();
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_vcount(int v);
		cfg_valid = 1;
		cfg_data = 6'(v);
		do @(posedge clk); while (!cfg_ready);
		board.vcount = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic send_graph(int nv, int ne);
		int a, b;
		for (int i = 0; i < ne; i++) begin
			a = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nv - 1) : $urandom_range(0, 31);
			b = ($urandom_range(0, 99) < 85) ? $urandom_range(0, nv - 1) : $urandom_range(0, 31);
			send_edge(a, b, i == ne - 1);
		end
	endtask

	initial begin : stimulus
		int nv;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Path with self-loop, parallel pair and an out-of-range edge
		write_vcount(5);
		send_edge(0, 1, 0);
		send_edge(1, 2, 0);
		send_edge(3, 3, 0);
		send_edge(2, 3, 0);
		send_edge(3, 2, 0);
		send_edge(4, 9, 1);
		// Triangle: no bridges
		send_edge(0, 1, 0);
		send_edge(1, 2, 0);
		send_edge(2, 0, 1);
		send_edge(31, 31, 1);
		settle();

		// Empty vertex set ignores every edge
		write_vcount(0);
		send_edge(1, 2, 0);
		send_edge(0, 0, 1);
		settle();
		write_vcount(1);
		send_edge(0, 0, 0);
		send_edge(0, 1, 1);
		settle();

		// Above the vertex limit: a 32-vertex chain gives the most bridges
		write_vcount(63);
		for (int i = 0; i < 31; i++)
			send_edge(i, i + 1, i == 30);
		settle();

		// Overfill the edge store; the dropped final edge still starts the search
		write_vcount(32);
		send_graph(32, 70);
		settle();

		// Receiver holds off while further graphs keep coming
		write_vcount(8);
		hold_req = 1;
		for (int g = 0; g < 4; g++)
			send_graph(8, $urandom_range(2, 7));
		settle();

		// Random graphs over several vertex counts
		while (items_sent < 150) begin
			nv = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(1, 12);
			write_vcount(nv);
			repeat ($urandom_range(2, 5))
				send_graph(nv, $urandom_range(1, 9));
			settle();
		end

		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
